FILE: sv/dmfp_pkg.sv
package dmfp_pkg;

  // Parse phases, one-hot.
  typedef enum logic [7:0] {
    PH_LEN_HI = 8'b0000_0001,
    PH_LEN_LO = 8'b0000_0010,
    PH_HEADER = 8'b0000_0100,
    PH_NAME   = 8'b0000_1000,
    PH_QTAIL  = 8'b0001_0000,
    PH_ANSWER = 8'b0010_0000,
    PH_RDATA  = 8'b0100_0000,
    PH_SKIP   = 8'b1000_0000
  } phase_t;

  // Result kinds.
  localparam logic [1:0] KIND_NAME_CHAR   = 2'd0;
  localparam logic [1:0] KIND_QUEST_AAAA  = 2'd1;
  localparam logic [1:0] KIND_ADDR_BYTE   = 2'd2;
  localparam logic [1:0] KIND_QUEST_OTHER = 2'd3;

  localparam logic [15:0] TYPE_AAAA          = 16'd28;
  localparam logic [3:0]  HEADER_BYTES       = 4'd12;
  localparam logic [3:0]  QTAIL_BYTES        = 4'd4;
  localparam logic [3:0]  ANSWER_FIXED_BYTES = 4'd12;
  localparam logic [7:0]  DOT_CHAR           = 8'h2E;

  // Header byte offsets that carry fields.
  localparam logic [3:0] OFF_ID_HI  = 4'd0;
  localparam logic [3:0] OFF_ID_LO  = 4'd1;
  localparam logic [3:0] OFF_FLAG_A = 4'd2;
  localparam logic [3:0] OFF_FLAG_B = 4'd3;
  localparam logic [3:0] OFF_AN_HI  = 4'd6;
  localparam logic [3:0] OFF_AN_LO  = 4'd7;

  // Question tail offsets.
  localparam logic [3:0] OFF_TYPE_HI  = 4'd0;
  localparam logic [3:0] OFF_TYPE_LO  = 4'd1;
  localparam logic [3:0] OFF_CLASS_HI = 4'd2;

  // Answer record offsets.
  localparam logic [3:0] OFF_TTL_FIRST = 4'd6;
  localparam logic [3:0] OFF_TTL_LAST  = 4'd9;
  localparam logic [3:0] OFF_RDLEN_HI  = 4'd10;
  localparam logic [3:0] OFF_RDLEN_LO  = 4'd11;

  // One result as it leaves the block.
  typedef struct packed {
    logic [1:0]  out_kind;
    logic [7:0]  out_byte;
    logic [15:0] message_id;
    logic        response_flag;
    logic [3:0]  operation_code;
    logic [3:0]  response_code;
    logic [15:0] answer_count;
    logic [15:0] record_type;
    logic [15:0] record_class;
    logic [31:0] time_to_live;
    logic        last_of_address;
  } result_t;

endpackage

FILE: sv/dns_message_field_parser_unit.sv
// DNS message field parser.
// Input channel: in_valid / in_stall carry one stream byte (data_byte) per
// request; the stream is a sequence of messages, each led by a two-byte
// big-endian length. Output channel: out_valid / out_stall carry one result
// per request: name characters and dots, a question-complete report, and,
// in response mode, the address bytes of the first answer with its ttl.
// Header fields ride along with every result.
// config_write / config_data set response_mode; write it only while idle.
// A taken byte waits in the input register and is parsed into the result
// register as soon as that register can take a result.
// Throughput: one byte per cycle while the receiver does not stall; the parse
// state updates between the input register and the result register.
// Bytes that make no result still pass through the input register.
// Reset clears the parser to await a length prefix and empties both
// registers. When the receiver stalls, the held result stays put, at most one
// more byte is taken into the input register, and then in_stall rises.
module dns_message_field_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        config_write,
  input  logic        config_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic [15:0] message_id,
  output logic        response_flag,
  output logic [3:0]  operation_code,
  output logic [3:0]  response_code,
  output logic [15:0] answer_count,
  output logic [15:0] record_type,
  output logic [15:0] record_class,
  output logic [31:0] time_to_live,
  output logic        last_of_address
);

  logic              response_mode;
  logic              in_full;
  logic [7:0]        in_byte;
  logic              res_free;
  logic              advance;
  logic              hit;
  dmfp_pkg::result_t result;
  dmfp_pkg::result_t result_q;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      response_mode <= 1'b0;
    end else if (config_write) begin
      response_mode <= config_data;
    end
  end

  // The held byte moves on when the result register can take a result.
  assign res_free = !out_valid || !out_stall;
  assign advance  = in_full && res_free;
  assign in_stall = in_full && !res_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte <= data_byte;
    end
  end

  dmfp_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .data_byte     (in_byte),
    .response_mode (response_mode),
    .hit           (hit),
    .result        (result)
  );

  dmfp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && hit),
    .result_in (result),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .result_q  (result_q)
  );

  // Result fields onto their ports.
  assign out_kind        = result_q.out_kind;
  assign out_byte        = result_q.out_byte;
  assign message_id      = result_q.message_id;
  assign response_flag   = result_q.response_flag;
  assign operation_code  = result_q.operation_code;
  assign response_code   = result_q.response_code;
  assign answer_count    = result_q.answer_count;
  assign record_type     = result_q.record_type;
  assign record_class    = result_q.record_class;
  assign time_to_live    = result_q.time_to_live;
  assign last_of_address = result_q.last_of_address;

endmodule

FILE: sv/dmfp_parser.sv
module dmfp_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              response_mode,
  output logic              hit,
  output dmfp_pkg::result_t result
);

  dmfp_pkg::phase_t phase, phase_next;
  logic [15:0] bytes_remaining, bytes_remaining_next;
  logic [3:0]  field_offset, field_offset_next;
  logic [7:0]  label_remaining, label_remaining_next;
  logic        label_seen, label_seen_next;
  logic [15:0] id_reg, id_reg_next;
  logic [8:0]  flag_bits, flag_bits_next;
  logic [15:0] answers, answers_next;
  logic [15:0] type_reg, type_reg_next;
  logic [15:0] class_reg, class_reg_next;
  logic [31:0] ttl_reg, ttl_reg_next;
  logic [15:0] data_left, data_left_next;

  logic [15:0] rem_dec;
  logic [15:0] len_full;
  logic [15:0] dl_dec;
  logic [3:0]  off_inc;
  logic [1:0]  kind;
  logic [7:0]  obyte;
  logic        last;

  // Field state update for one message byte.
  always_comb begin
    phase_next           = phase;
    bytes_remaining_next = bytes_remaining;
    field_offset_next    = field_offset;
    label_remaining_next = label_remaining;
    label_seen_next      = label_seen;
    id_reg_next          = id_reg;
    flag_bits_next       = flag_bits;
    answers_next         = answers;
    type_reg_next        = type_reg;
    class_reg_next       = class_reg;
    ttl_reg_next         = ttl_reg;
    data_left_next       = data_left;
    hit                  = 1'b0;
    kind                 = dmfp_pkg::KIND_NAME_CHAR;
    obyte                = 8'h00;
    last                 = 1'b0;
    rem_dec              = bytes_remaining - 16'd1;
    len_full             = {bytes_remaining[15:8], data_byte};
    dl_dec               = data_left - 16'd1;
    off_inc              = field_offset + 4'd1;

    case (phase)
      dmfp_pkg::PH_LEN_HI: begin
        bytes_remaining_next = {data_byte, 8'h00};
        phase_next           = dmfp_pkg::PH_LEN_LO;
      end
      dmfp_pkg::PH_LEN_LO: begin
        bytes_remaining_next = len_full;
        type_reg_next        = '0;
        class_reg_next       = '0;
        ttl_reg_next         = '0;
        field_offset_next    = '0;
        phase_next = (len_full == 16'd0) ? dmfp_pkg::PH_LEN_HI : dmfp_pkg::PH_HEADER;
      end
      default: begin
        bytes_remaining_next = rem_dec;
        case (phase)
          dmfp_pkg::PH_HEADER: begin
            case (field_offset)
              dmfp_pkg::OFF_ID_HI:  id_reg_next = {data_byte, 8'h00};
              dmfp_pkg::OFF_ID_LO:  id_reg_next = id_reg | {8'h00, data_byte};
              dmfp_pkg::OFF_FLAG_A: flag_bits_next = {data_byte[7], data_byte[6:3],
                                                      flag_bits[3:0]};
              dmfp_pkg::OFF_FLAG_B: flag_bits_next = {flag_bits[8:4], data_byte[3:0]};
              dmfp_pkg::OFF_AN_HI:  answers_next = {data_byte, 8'h00};
              dmfp_pkg::OFF_AN_LO:  answers_next = answers | {8'h00, data_byte};
              default: ;
            endcase
            if (off_inc >= dmfp_pkg::HEADER_BYTES) begin
              field_offset_next    = '0;
              label_remaining_next = '0;
              label_seen_next      = 1'b0;
              phase_next           = dmfp_pkg::PH_NAME;
            end else begin
              field_offset_next = off_inc;
            end
          end
          dmfp_pkg::PH_NAME: begin
            if (label_remaining != 8'd0) begin
              hit                  = 1'b1;
              kind                 = dmfp_pkg::KIND_NAME_CHAR;
              obyte                = data_byte;
              label_remaining_next = label_remaining - 8'd1;
              label_seen_next      = 1'b1;
            end else if (data_byte == 8'd0) begin
              field_offset_next = '0;
              phase_next        = dmfp_pkg::PH_QTAIL;
            end else begin
              label_remaining_next = data_byte;
              if (label_seen) begin
                hit             = 1'b1;
                kind            = dmfp_pkg::KIND_NAME_CHAR;
                obyte           = dmfp_pkg::DOT_CHAR;
                label_seen_next = 1'b0;
              end
            end
          end
          dmfp_pkg::PH_QTAIL: begin
            case (field_offset)
              dmfp_pkg::OFF_TYPE_HI:  type_reg_next = {data_byte, 8'h00};
              dmfp_pkg::OFF_TYPE_LO:  type_reg_next = type_reg | {8'h00, data_byte};
              dmfp_pkg::OFF_CLASS_HI: class_reg_next = {data_byte, 8'h00};
              default:                class_reg_next = class_reg | {8'h00, data_byte};
            endcase
            if (off_inc >= dmfp_pkg::QTAIL_BYTES) begin
              field_offset_next = '0;
              hit               = 1'b1;
              if (type_reg_next == dmfp_pkg::TYPE_AAAA) begin
                kind       = dmfp_pkg::KIND_QUEST_AAAA;
                phase_next = (response_mode && answers != 16'd0) ?
                             dmfp_pkg::PH_ANSWER : dmfp_pkg::PH_SKIP;
              end else begin
                kind       = dmfp_pkg::KIND_QUEST_OTHER;
                phase_next = dmfp_pkg::PH_SKIP;
              end
            end else begin
              field_offset_next = off_inc;
            end
          end
          dmfp_pkg::PH_ANSWER: begin
            if (field_offset >= dmfp_pkg::OFF_TTL_FIRST &&
                field_offset <= dmfp_pkg::OFF_TTL_LAST) begin
              ttl_reg_next = {ttl_reg[23:0], data_byte};
            end else if (field_offset == dmfp_pkg::OFF_RDLEN_HI) begin
              data_left_next = {data_byte, 8'h00};
            end else if (field_offset == dmfp_pkg::OFF_RDLEN_LO) begin
              data_left_next = data_left | {8'h00, data_byte};
            end
            if (off_inc >= dmfp_pkg::ANSWER_FIXED_BYTES) begin
              field_offset_next = '0;
              phase_next = (data_left_next == 16'd0) ?
                           dmfp_pkg::PH_SKIP : dmfp_pkg::PH_RDATA;
            end else begin
              field_offset_next = off_inc;
            end
          end
          dmfp_pkg::PH_RDATA: begin
            data_left_next = dl_dec;
            hit            = 1'b1;
            kind           = dmfp_pkg::KIND_ADDR_BYTE;
            obyte          = data_byte;
            last           = (dl_dec == 16'd0);
            if (dl_dec == 16'd0) begin
              phase_next = dmfp_pkg::PH_SKIP;
            end
          end
          default: ;
        endcase
        // The message length has run out: wait for the next prefix.
        if (rem_dec == 16'd0) begin
          phase_next = dmfp_pkg::PH_LEN_HI;
        end
      end
    endcase
  end

  // Result fields reflect the registers after this byte's update.
  always_comb begin
    result.out_kind        = kind;
    result.out_byte        = obyte;
    result.message_id      = id_reg_next;
    result.response_flag   = flag_bits_next[8];
    result.operation_code  = flag_bits_next[7:4];
    result.response_code   = flag_bits_next[3:0];
    result.answer_count    = answers_next;
    result.record_type     = type_reg_next;
    result.record_class    = class_reg_next;
    result.time_to_live    = ttl_reg_next;
    result.last_of_address = last;
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= dmfp_pkg::PH_LEN_HI;
      bytes_remaining <= '0;
      field_offset    <= '0;
      label_remaining <= '0;
      label_seen      <= 1'b0;
      id_reg          <= '0;
      flag_bits       <= '0;
      answers         <= '0;
      type_reg        <= '0;
      class_reg       <= '0;
      ttl_reg         <= '0;
      data_left       <= '0;
    end else if (step) begin
      phase           <= phase_next;
      bytes_remaining <= bytes_remaining_next;
      field_offset    <= field_offset_next;
      label_remaining <= label_remaining_next;
      label_seen      <= label_seen_next;
      id_reg          <= id_reg_next;
      flag_bits       <= flag_bits_next;
      answers         <= answers_next;
      type_reg        <= type_reg_next;
      class_reg       <= class_reg_next;
      ttl_reg         <= ttl_reg_next;
      data_left       <= data_left_next;
    end
  end

endmodule

FILE: sv/dmfp_out_reg.sv
module dmfp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  dmfp_pkg::result_t result_in,
  input  logic              out_stall,
  output logic              out_valid,
  output dmfp_pkg::result_t result_q
);

  // Result register: holds a request until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      result_q <= result_in;
    end
  end

endmodule
